// ===== design/nnt_pkg.sv =====
// Package for the nearest-neighbor tour block: item types, codes and constants.
// Used by the top level; depends on nothing.
package nnt_pkg;

  localparam int DEF_MAX_CITIES = 16;
  localparam int CITY_W         = 4;
  localparam int COST_W         = 10;
  localparam int TOTAL_W        = 16;
  localparam int NUM_W          = 5;
  localparam int MASK_W         = 16;
  localparam int CFG_W          = 5;

  // An edge cost at or above this value is unusable.
  localparam logic [COST_W-1:0] NO_EDGE = 10'd999;

  // Operation codes of an input item.
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TOUR = 1'b1;

  // Configuration register indexes.
  localparam logic CFG_NUM_CITIES = 1'b0;
  localparam logic CFG_START_CITY = 1'b1;

  localparam logic [NUM_W-1:0]  NUM_CITIES_RST = 5'd16;
  localparam logic [CITY_W-1:0] START_CITY_RST = 4'd0;

  typedef struct packed {
    logic              op;
    logic [CITY_W-1:0] from_city;
    logic [CITY_W-1:0] to_city;
    logic [COST_W-1:0] edge_cost;
  } in_item_t;

  typedef struct packed {
    logic [CITY_W-1:0]  city;
    logic [TOTAL_W-1:0] tour_cost;
    logic               no_route;
    logic               last;
  } out_item_t;

endpackage

// ===== design/nnt_stream_if.sv =====
// Valid/ready stream channel carrying one item of type T.
// Depends on nothing; item types come from nnt_pkg at the instantiation site.
interface nnt_stream_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== design/nearest_neighbor_tour.sv =====
// Greedy nearest-neighbor tour over a cost matrix held in an internal memory.
// A load item writes one matrix entry. A tour over n cities scans one matrix row per step,
// one entry per cycle through the single registered read port and a shared compare unit;
// output stalls hold the tour in its emit state.
// Reset (rst_n, synchronous, active low) clears control state and loads the register
// defaults; the cost memory is undefined until written.
module nearest_neighbor_tour
  import nnt_pkg::*;
#(
  parameter int MAX_CITIES = DEF_MAX_CITIES
) (
  input  logic               clk,
  input  logic               rst_n,
  nnt_stream_if.sink         in_ch,
  nnt_stream_if.source       out_ch,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [CFG_W-1:0]   cfg_wdata
);

  localparam int DEPTH    = MAX_CITIES * MAX_CITIES;
  localparam int AW       = $clog2(DEPTH);
  localparam int CITY_CAP = (MAX_CITIES < MASK_W) ? MAX_CITIES : MASK_W;
  localparam logic [AW-1:0] ROW_STRIDE = AW'(MAX_CITIES);

  typedef enum logic [6:0] {
    ST_IDLE     = 7'b0000001,
    ST_SCAN     = 7'b0000010,
    ST_FIN      = 7'b0000100,
    ST_DECIDE   = 7'b0001000,
    ST_EMIT     = 7'b0010000,
    ST_RET      = 7'b0100000,
    ST_RET_WAIT = 7'b1000000
  } state_t;

  // Next action after a result has been handed to the output register.
  typedef enum logic [2:0] {
    NX_IDLE = 3'b001,
    NX_SCAN = 3'b010,
    NX_RET  = 3'b100
  } next_t;

  in_item_t in_item;
  assign in_item = in_ch.data;

  // Configuration registers.
  logic [NUM_W-1:0]  num_cities_r;
  logic [CITY_W-1:0] start_city_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_cities_r <= NUM_CITIES_RST;
      start_city_r <= START_CITY_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_NUM_CITIES: num_cities_r <= cfg_wdata;
        CFG_START_CITY: start_city_r <= cfg_wdata[CITY_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer and datapath registers.
  state_t             state_r, state_nxt;
  next_t              next_r, next_nxt;
  logic [NUM_W-1:0]   n_r, n_nxt;
  logic [CITY_W-1:0]  s_r, s_nxt;
  logic [MASK_W-1:0]  visited_r, visited_nxt;
  logic [CITY_W-1:0]  cur_r, cur_nxt;
  logic [TOTAL_W-1:0] total_r, total_nxt;
  logic [NUM_W-1:0]   step_r, step_nxt;
  logic [CITY_W-1:0]  j_r, j_nxt;
  logic [COST_W-1:0]  best_r, best_nxt;
  logic [CITY_W-1:0]  pick_r, pick_nxt;
  logic               found_r, found_nxt;
  logic               rd_vld_r, rd_vld_nxt;
  logic [CITY_W-1:0]  rd_j_r, rd_j_nxt;
  logic               ret_ok_r, ret_ok_nxt;
  out_item_t          res_r, res_nxt;
  out_item_t          out_r, out_nxt;
  logic               out_valid_r, out_valid_nxt;

  // Cost memory: one write port, one registered read port.
  logic [COST_W-1:0] mem [DEPTH];
  logic [COST_W-1:0] mem_q;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic              rd_en;
  logic [AW-1:0]     rd_addr;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= in_item.edge_cost;
    end
    if (rd_en) begin
      mem_q <= mem[rd_addr];
    end
  end

  logic in_fire;
  logic emit_ok;
  logic cand_ok;
  logic [NUM_W-1:0] n_clamp;
  logic [NUM_W:0]   step_inc;

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign emit_ok      = !out_valid_r || out_ch.ready;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_r;

  // Load address from the item's row and column.
  assign wr_addr = AW'(in_item.from_city) * ROW_STRIDE + AW'(in_item.to_city);
  assign wr_en   = in_fire && (in_item.op == OP_LOAD)
                   && (int'(in_item.from_city) < MAX_CITIES)
                   && (int'(in_item.to_city) < MAX_CITIES);

  // City count clamped to two and to the cap.
  always_comb begin
    n_clamp = num_cities_r;
    if (n_clamp < NUM_W'(2)) begin
      n_clamp = NUM_W'(2);
    end
    if (int'(n_clamp) > CITY_CAP) begin
      n_clamp = NUM_W'(CITY_CAP);
    end
  end

  // Shared compare unit: a usable, cheaper, unvisited entry replaces the best so far.
  // A current row outside the memory holds no usable edge.
  assign cand_ok = rd_vld_r && (int'(cur_r) < MAX_CITIES) && (mem_q != '0)
                   && (mem_q < best_r) && !visited_r[rd_j_r];

  always_comb begin
    state_nxt     = state_r;
    next_nxt      = next_r;
    n_nxt         = n_r;
    s_nxt         = s_r;
    visited_nxt   = visited_r;
    cur_nxt       = cur_r;
    total_nxt     = total_r;
    step_nxt      = step_r;
    j_nxt         = j_r;
    best_nxt      = best_r;
    pick_nxt      = pick_r;
    found_nxt     = found_r;
    rd_vld_nxt    = 1'b0;
    rd_j_nxt      = rd_j_r;
    ret_ok_nxt    = ret_ok_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    rd_en         = 1'b0;
    rd_addr       = AW'(cur_r) * ROW_STRIDE + AW'(j_r);
    step_inc      = {1'b0, step_r} + 1'b1;

    if (cand_ok && ((state_r == ST_SCAN) || (state_r == ST_FIN))) begin
      best_nxt  = mem_q;
      pick_nxt  = rd_j_r;
      found_nxt = 1'b1;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_fire && (in_item.op == OP_TOUR)) begin
          n_nxt       = n_clamp;
          s_nxt       = start_city_r;
          visited_nxt = MASK_W'(1) << start_city_r;
          cur_nxt     = start_city_r;
          total_nxt   = '0;
          step_nxt    = '0;
          j_nxt       = '0;
          best_nxt    = NO_EDGE;
          pick_nxt    = '0;
          found_nxt   = 1'b0;
          state_nxt   = ST_SCAN;
        end
      end
      // Issue one read of the current row per cycle.
      ST_SCAN: begin
        rd_en      = 1'b1;
        rd_vld_nxt = 1'b1;
        rd_j_nxt   = j_r;
        if ({1'b0, j_r} == n_r - 1'b1) begin
          state_nxt = ST_FIN;
        end else begin
          j_nxt = j_r + 1'b1;
        end
      end
      // The last entry is compared here.
      ST_FIN: begin
        state_nxt = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (!found_r) begin
          res_nxt   = '{city: '0, tour_cost: total_r, no_route: 1'b1, last: 1'b1};
          next_nxt  = NX_IDLE;
        end else begin
          visited_nxt = visited_r | (MASK_W'(1) << pick_r);
          total_nxt   = total_r + TOTAL_W'(best_r);
          cur_nxt     = pick_r;
          step_nxt    = step_inc[NUM_W-1:0];
          res_nxt     = '{city: pick_r, tour_cost: total_r + TOTAL_W'(best_r),
                          no_route: 1'b0, last: 1'b0};
          next_nxt    = ((step_inc + 1'b1) < {1'b0, n_r}) ? NX_SCAN : NX_RET;
        end
        state_nxt = ST_EMIT;
      end
      // Hand the result to the output register, then continue.
      ST_EMIT: begin
        if (emit_ok) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          case (next_r)
            NX_SCAN: begin
              j_nxt     = '0;
              best_nxt  = NO_EDGE;
              pick_nxt  = '0;
              found_nxt = 1'b0;
              state_nxt = ST_SCAN;
            end
            NX_RET:  state_nxt = ST_RET;
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      // Read the return edge; a start city outside the memory costs nothing.
      ST_RET: begin
        rd_addr    = AW'(cur_r) * ROW_STRIDE + AW'(s_r);
        ret_ok_nxt = (int'(s_r) < MAX_CITIES);
        rd_en      = (int'(s_r) < MAX_CITIES);
        state_nxt  = ST_RET_WAIT;
      end
      ST_RET_WAIT: begin
        total_nxt = total_r + (ret_ok_r ? TOTAL_W'(mem_q) : '0);
        cur_nxt   = s_r;
        res_nxt   = '{city: s_r, tour_cost: total_r + (ret_ok_r ? TOTAL_W'(mem_q) : '0),
                      no_route: 1'b0, last: 1'b1};
        next_nxt  = NX_IDLE;
        state_nxt = ST_EMIT;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control registers take reset; payload registers do not.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      next_r      <= NX_IDLE;
      out_valid_r <= 1'b0;
      rd_vld_r    <= 1'b0;
      visited_r   <= '0;
      cur_r       <= '0;
      total_r     <= '0;
      step_r      <= '0;
      found_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      next_r      <= next_nxt;
      out_valid_r <= out_valid_nxt;
      rd_vld_r    <= rd_vld_nxt;
      visited_r   <= visited_nxt;
      cur_r       <= cur_nxt;
      total_r     <= total_nxt;
      step_r      <= step_nxt;
      found_r     <= found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r      <= n_nxt;
    s_r      <= s_nxt;
    j_r      <= j_nxt;
    best_r   <= best_nxt;
    pick_r   <= pick_nxt;
    rd_j_r   <= rd_j_nxt;
    ret_ok_r <= ret_ok_nxt;
    res_r    <= res_nxt;
    out_r    <= out_nxt;
  end

  // The start city stays marked visited for the whole tour.
  a_start_visited: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> visited_r[s_r])
    else $error("start city not marked visited during a tour");

  // A recorded best candidate is always a usable edge.
  a_best_usable: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_DECIDE) && found_r) |-> ((best_r != '0) && (best_r < NO_EDGE)))
    else $error("best candidate is not a usable edge");

  // Scanning only happens while steps remain.
  a_steps_left: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (({1'b0, step_r} + 1'b1) < {1'b0, n_r}))
    else $error("row scan started with no steps left");

  // Finishing a tour leaves a last result in the output register.
  a_tour_ends_last: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_EMIT) && emit_ok && (next_r == NX_IDLE)) |=> (out_valid_r && out_r.last))
    else $error("tour ended without a last result");

endmodule
